>>> hw/rtl/cmr_pkg.sv
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler package
// Field widths and stream packing constants shared by the block and its
// checker.
// ----------------------------------------------------------------------------
package cmr_pkg;

  // Input request fields.
  localparam int unsigned CanIdW     = 16;
  localparam int unsigned FrameLenW  = 8;
  localparam int unsigned FrameDataW = 64;
  localparam int unsigned STdataW    = 88;

  // Result fields.
  localparam int unsigned UnitW      = 4;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned MsgLenW    = 7;
  localparam int unsigned MTdataW    = 24;

  // Bit positions inside the result tdata word.
  localparam int unsigned MUnitLsb   = 0;
  localparam int unsigned MByteLsb   = 4;
  localparam int unsigned MLenLsb    = 12;

  // Result payload, most significant member first.
  typedef struct packed {
    logic [MTdataW-MLenLsb-MsgLenW-1:0] pad;
    logic [MsgLenW-1:0]                 message_length;
    logic [ByteW-1:0]                   data_byte;
    logic [UnitW-1:0]                   unit;
  } out_word_t;

endpackage

>>> hw/rtl/can_multiframe_reassembler.sv
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler
// Appends CAN frame payloads to per-unit buffers and streams out each
// completed message one byte per result.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one CAN frame per request: can_id, raw length byte and
//   eight data bytes. The unit is can_id minus the base identifier written on
//   cfg_we_i/cfg_wdata_i; frames outside the unit range are dropped.
//   m_axis carries one byte of a completed message per request, with tlast on
//   the final byte; an empty message gives one request with tuser low.
//   A frame takes a fill read and then one write per byte it stores (at
//   most 8) on the single write port of the message memory. A frame
//   that completes a message then emits each output byte through a
//   registered memory read and a load of the output register.
//   s_axis_tready is high only while no frame is in work. The final result
//   may still wait in the output register while the next frame is taken.
//   Reset clears the per-unit fill valid bits and the control state; the
//   message memory needs no clearing. A stalled receiver holds the output
//   register and the readout simply waits for it.
// ----------------------------------------------------------------------------
module can_multiframe_reassembler #(
  parameter int unsigned NUM_UNITS    = 16,
  parameter int unsigned FRAME_BYTES  = 8,
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cmr_pkg::CanIdW-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // can_id [15:0], frame_len [23:16], frame_data [87:24]
  input  logic [cmr_pkg::STdataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // unit [3:0], data_byte [11:4], message_length [18:12], zeros [23:19]
  output logic [cmr_pkg::MTdataW-1:0]  m_axis_tdata,
  // has_byte [0]
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast
);

  localparam int unsigned UnitIdxW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int unsigned StoreD   = NUM_UNITS * BUFFER_BYTES;
  localparam int unsigned StoreAW  = (StoreD > 1) ? $clog2(StoreD) : 1;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StRdFill = 3'd1;
  localparam logic [2:0] StWrite  = 3'd2;
  localparam logic [2:0] StEmitRd = 3'd3;
  localparam logic [2:0] StEmitLd = 3'd4;

  logic [2:0] state_q, state_d;

  logic [cmr_pkg::CanIdW-1:0] base_id_q;

  // Request fields.
  logic [cmr_pkg::CanIdW-1:0]     in_id;
  logic [cmr_pkg::FrameLenW-1:0]  in_len;
  logic [cmr_pkg::FrameDataW-1:0] in_data;
  logic [cmr_pkg::CanIdW:0]       unit_diff;
  logic                           in_range;
  logic                           s_fire;

  logic [UnitIdxW-1:0]            unit_q;
  logic [3:0]                     len_q;
  logic [3:0]                     len_clamp;
  logic [cmr_pkg::FrameDataW-1:0] data_q;
  logic [StoreAW-1:0]             base_addr_q;
  logic [cmr_pkg::MsgLenW-1:0]    fill_q, fill_d;
  logic [3:0]                     take_q, take_d;
  logic [2:0]                     cnt_q;
  logic [cmr_pkg::MsgLenW-1:0]    idx_q;
  logic [NUM_UNITS-1:0]           fill_valid_q;

  // Fill level memory.
  logic                        fill_we;
  logic [cmr_pkg::MsgLenW-1:0] fill_wdata;
  logic [cmr_pkg::MsgLenW-1:0] fill_rdata;
  logic [cmr_pkg::MsgLenW-1:0] fill_rd;
  logic [cmr_pkg::MsgLenW-1:0] space;

  // Message memory.
  logic                      store_we;
  logic [StoreAW-1:0]        store_waddr;
  logic [StoreAW-1:0]        store_raddr;
  logic [cmr_pkg::ByteW-1:0] store_rdata;

  logic                      complete;
  logic                      out_free;
  logic                      is_last;
  logic [UnitIdxW+3:0]       unit_ext;

  logic                        m_valid_q;
  logic                        m_last_q;
  logic                        m_has_q;
  cmr_pkg::out_word_t          m_word_q;

  assign in_id   = s_axis_tdata[15:0];
  assign in_len  = s_axis_tdata[23:16];
  assign in_data = s_axis_tdata[87:24];

  assign unit_diff = {1'b0, in_id} - {1'b0, base_id_q};
  assign in_range  = !unit_diff[cmr_pkg::CanIdW] &&
                     (unit_diff[cmr_pkg::CanIdW-1:0] < cmr_pkg::CanIdW'(NUM_UNITS));

  assign s_axis_tready = (state_q == StIdle);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign len_clamp = (in_len > cmr_pkg::FrameLenW'(FRAME_BYTES)) ? 4'(FRAME_BYTES)
                                                                  : in_len[3:0];

  // A fill entry never written since reset reads as an empty buffer.
  assign fill_rd = fill_valid_q[unit_q] ? fill_rdata : '0;
  assign space   = cmr_pkg::MsgLenW'(BUFFER_BYTES) - fill_rd;

  assign complete = (len_q != 4'(FRAME_BYTES));
  assign out_free = !m_valid_q || m_axis_tready;
  assign is_last  = (fill_q == '0) || ((idx_q + 1'b1) == fill_q);

  assign fill_we    = (state_q == StWrite) && (take_q == '0);
  assign fill_wdata = complete ? '0 : fill_q;

  assign store_we    = (state_q == StWrite) && (take_q != '0);
  assign store_waddr = base_addr_q + StoreAW'(fill_q);
  assign store_raddr = base_addr_q + StoreAW'(idx_q);

  always_comb begin
    take_d = take_q;
    fill_d = fill_q;
    if (state_q == StRdFill) begin
      fill_d = fill_rd;
      take_d = ({3'b0, len_q} > space) ? space[3:0] : len_q;
    end else if (store_we) begin
      fill_d = fill_q + 1'b1;
      take_d = take_q - 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_fire && in_range) begin
          state_d = StRdFill;
        end
      end
      StRdFill: begin
        state_d = StWrite;
      end
      StWrite: begin
        if (take_q == '0) begin
          state_d = complete ? StEmitRd : StIdle;
        end
      end
      StEmitRd: begin
        if (out_free) begin
          state_d = StEmitLd;
        end
      end
      StEmitLd: begin
        state_d = is_last ? StIdle : StEmitRd;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      base_id_q    <= '0;
      fill_valid_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        base_id_q <= cfg_wdata_i;
      end
      if (fill_we) begin
        fill_valid_q[unit_q] <= 1'b1;
      end
      if (state_q == StEmitLd) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    take_q <= take_d;
    fill_q <= fill_d;
    if (s_fire) begin
      unit_q <= unit_diff[UnitIdxW-1:0];
      len_q  <= len_clamp;
      data_q <= in_data;
    end
    if (state_q == StRdFill) begin
      base_addr_q <= StoreAW'(unit_q * BUFFER_BYTES);
      cnt_q       <= '0;
      idx_q       <= '0;
    end
    if (store_we) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (state_q == StEmitLd) begin
      idx_q                   <= idx_q + 1'b1;
      m_word_q.pad            <= '0;
      m_word_q.message_length <= fill_q;
      m_word_q.data_byte      <= (fill_q != '0) ? store_rdata : '0;
      m_word_q.unit           <= unit_ext[3:0];
      m_has_q                 <= (fill_q != '0);
      m_last_q                <= is_last;
    end
  end

  assign unit_ext = {4'b0, unit_q};

  cmr_ram #(
    .Width (cmr_pkg::MsgLenW),
    .Depth (NUM_UNITS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (unit_q),
    .wdata_i (fill_wdata),
    .raddr_i (unit_diff[UnitIdxW-1:0]),
    .rdata_o (fill_rdata)
  );

  cmr_ram #(
    .Width (cmr_pkg::ByteW),
    .Depth (StoreD)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (data_q[cnt_q*8 +: 8]),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_word_q;
  assign m_axis_tuser  = m_has_q;
  assign m_axis_tlast  = m_last_q;

endmodule

>>> hw/rtl/cmr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cmr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/cmr_checker.sv
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler port checker
// Watches the stream ports of the reassembler for consistent results.
// ----------------------------------------------------------------------------
module cmr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [cmr_pkg::MTdataW-1:0]  m_axis_tdata,
  input logic                         m_axis_tuser,
  input logic                         m_axis_tlast
);

  logic [cmr_pkg::MsgLenW-1:0] msg_len;

  assign msg_len = m_axis_tdata[cmr_pkg::MLenLsb +: cmr_pkg::MsgLenW];

  // A stalled result request is held until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result request dropped or changed while stalled");

  // An empty message is a single result of length zero.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (msg_len == '0))
    else $error("empty message result malformed");

  // A result carrying a byte belongs to a message of nonzero length.
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (msg_len != '0))
    else $error("byte result with zero message length");

  // A new frame is taken only after the readout has reached the last byte.
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("frame taken in the middle of a message readout");

endmodule

bind can_multiframe_reassembler cmr_checker u_cmr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/can_multiframe_reassembler_test.sv
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler testbench
// Drives CAN frames on the input stream under several base identifiers,
// predicts each unit's reassembled message in a scoreboard and checks every
// output byte, its length, its marker bits and the end-of-message flag,
// with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module can_multiframe_reassembler_test;

  localparam int NumUnits    = 16;
  localparam int FrameBytes  = 8;
  localparam int BufferBytes = 64;
  localparam int SettleCycles = 40;
  localparam int CycleLimit   = 600000;
  localparam int MaxReports   = 10;

  typedef struct {
    logic [cmr_pkg::UnitW-1:0]   unit;
    logic [cmr_pkg::ByteW-1:0]   data_byte;
    logic                        has_byte;
    logic [cmr_pkg::MsgLenW-1:0] message_length;
    logic                        last;
  } reassembled_byte_t;

  class reassembly_scoreboard;
    logic [cmr_pkg::CanIdW-1:0] base_id;
    int                         fill[NumUnits];
    bit                         active[NumUnits];
    logic [7:0]                 store[NumUnits][BufferBytes];
    reassembled_byte_t          expected_bytes[$];
    int                         errors;
    int                         messages;
    int                         bytes_checked;

    function new();
      base_id = '0;
      foreach (fill[i]) begin
        fill[i]   = 0;
        active[i] = 1'b0;
      end
      errors        = 0;
      messages      = 0;
      bytes_checked = 0;
    endfunction

    function void report(string what);
      errors++;
      if (errors <= MaxReports) $display("mismatch: %s", what);
    endfunction

    // Predicts the bytes a frame releases, if it ends a message.
    function void note_frame(logic [cmr_pkg::STdataW-1:0] word);
      logic [15:0]       id;
      logic [63:0]       data;
      int                u;
      int                len;
      int                take;
      reassembled_byte_t e;
      id   = word[15:0];
      len  = int'(word[23:16]);
      data = word[87:24];
      u    = int'(id) - int'(base_id);
      if (u < 0 || u >= NumUnits) return;
      if (len > FrameBytes) len = FrameBytes;
      if (!active[u]) begin
        active[u] = 1'b1;
        fill[u]   = 0;
      end
      take = len;
      if (fill[u] + take > BufferBytes) take = BufferBytes - fill[u];
      for (int i = 0; i < take; i++) store[u][fill[u] + i] = data[8*i +: 8];
      fill[u] += take;
      if (len >= FrameBytes) return;
      messages++;
      e.unit = u[3:0];
      if (fill[u] == 0) begin
        e.data_byte      = '0;
        e.has_byte       = 1'b0;
        e.message_length = '0;
        e.last           = 1'b1;
        expected_bytes.push_back(e);
      end else begin
        for (int k = 0; k < fill[u]; k++) begin
          e.data_byte      = store[u][k];
          e.has_byte       = 1'b1;
          e.message_length = fill[u][6:0];
          e.last           = (k + 1 == fill[u]);
          expected_bytes.push_back(e);
        end
      end
      active[u] = 1'b0;
      fill[u]   = 0;
    endfunction

    function void check_byte(logic [cmr_pkg::MTdataW-1:0] tdata, logic has, logic last);
      cmr_pkg::out_word_t w;
      reassembled_byte_t  e;
      w = tdata;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected result unit %0d byte %02h len %0d last %0d",
                         w.unit, w.data_byte, w.message_length, last));
        return;
      end
      e = expected_bytes.pop_front();
      if (w.unit !== e.unit || w.data_byte !== e.data_byte || has !== e.has_byte ||
          w.message_length !== e.message_length || last !== e.last || w.pad !== '0) begin
        report($sformatf({"expected unit %0d byte %02h has %0d len %0d last %0d, ",
                          "got unit %0d byte %02h has %0d len %0d last %0d pad %0h"},
                         e.unit, e.data_byte, e.has_byte, e.message_length, e.last,
                         w.unit, w.data_byte, has, w.message_length, last, w.pad));
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [cmr_pkg::CanIdW-1:0]   cfg_wdata_i;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [cmr_pkg::STdataW-1:0]  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [cmr_pkg::MTdataW-1:0]  m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         m_axis_tlast;

  reassembly_scoreboard sb = new();

  int cycles;
  int burst_left;
  int frames_sent;
  int frames_in_range;
  int base_settings;
  bit hold_request;

  can_multiframe_reassembler #(
    .NUM_UNITS   (NumUnits),
    .FRAME_BYTES (FrameBytes),
    .BUFFER_BYTES(BufferBytes)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.expected_bytes.size());
      $display("** can_multiframe_reassembler: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_frame(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Receiver: stretches of random stall styles, plus one long hold on request.
  initial begin
    int stretch;
    int style;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      stretch = $urandom_range(1, 40);
      style   = $urandom_range(0, 3);
      repeat (stretch) begin
        @(negedge clk_i);
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_frame(logic [15:0] id, logic [7:0] len, logic [63:0] data);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, len, id};
    do @(posedge clk_i); while (!s_axis_tready);
    frames_sent++;
  endtask

  // Sender stops until every predicted byte is out and any trailing frame is done.
  task automatic drain();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_base(logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    sb.base_id = value;
    base_settings++;
  endtask

  task automatic send_unit(int u, logic [7:0] len, logic [63:0] data);
    send_frame(16'(int'(sb.base_id) + u), len, data);
    frames_in_range++;
  endtask

  task automatic run_traffic(int quota, bit with_hold);
    int          sent;
    int          max_u;
    int          pick;
    int          id;
    logic [7:0]  len;
    sent  = 0;
    max_u = 65535 - int'(sb.base_id);
    if (max_u > NumUnits - 1) max_u = NumUnits - 1;
    while (sent < quota) begin
      if (with_hold && sent == quota / 3) hold_request = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        do id = $urandom_range(0, 65535);
        while (id >= int'(sb.base_id) && id - int'(sb.base_id) < NumUnits);
        send_frame(16'(id), 8'($urandom_range(0, 255)), {$urandom, $urandom});
      end else begin
        pick = $urandom_range(0, 15);
        if (pick < 4) len = 8'($urandom_range(0, FrameBytes - 1));
        else if (pick == 4) len = 8'($urandom_range(FrameBytes + 1, 255));
        else len = 8'(FrameBytes);
        send_unit($urandom_range(0, max_u), len, {$urandom, $urandom});
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_request  = 1'b0;
    cycles          = 0;
    burst_left      = 0;
    frames_sent     = 0;
    frames_in_range = 0;
    base_settings   = 1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames with the base identifier still at its reset value.
    send_unit(0, 8'd0, {$urandom, $urandom});          // empty message
    send_unit(15, 8'd3, '1);                          // top unit, all-ones data
    send_unit(1, 8'd8, '0);
    send_unit(1, 8'hFF, {$urandom, $urandom});        // long length byte clamps
    send_unit(1, 8'h80, {$urandom, $urandom});
    send_unit(1, 8'd7, {$urandom, $urandom});
    send_frame(16'd16, 8'd0, '1);                     // just past the last unit
    send_frame(16'hFFFF, 8'd5, {$urandom, $urandom});
    for (int i = 0; i < 9; i++) send_unit(2, 8'h7F, {$urandom, $urandom});
    send_unit(2, 8'd4, {$urandom, $urandom});         // buffer saturated
    send_unit(4, 8'd8, {$urandom, $urandom});         // interleaved units
    send_unit(5, 8'd2, {$urandom, $urandom});
    send_unit(4, 8'd1, {$urandom, $urandom});
    send_unit(3, 8'd8, {$urandom, $urandom});
    send_unit(3, 8'd0, {$urandom, $urandom});
    drain();

    write_base(16'hFFFF);
    send_unit(0, 8'd6, {$urandom, $urandom});
    run_traffic(30, 1'b0);
    write_base(16'($urandom_range(0, 65535)));
    run_traffic(80, 1'b1);
    write_base(16'hFFF0);
    run_traffic(80, 1'b0);
    write_base(16'($urandom_range(0, 65535)));
    run_traffic(80, 1'b0);
    write_base(16'h0000);
    run_traffic(80, 1'b0);

    if (sb.expected_bytes.size() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.expected_bytes.size()));
    $display("Sent %0d frames (%0d to valid units) under %0d base identifiers.",
             frames_sent, frames_in_range, base_settings);
    $display("Checked %0d output bytes from %0d completed messages, %0d errors.",
             sb.bytes_checked, sb.messages, sb.errors);
    if (sb.errors == 0) begin
      $display("** can_multiframe_reassembler: PASSED **");
    end else begin
      $display("** can_multiframe_reassembler: FAILED **");
    end
    $finish;
  end

endmodule
